@@ src/rdss_pkg.sv @@
// Shared widths, register indexes and port packing constants for the radial deadzone scaler.
package rdss_pkg;

    // Sample and result field widths.
    localparam int AXIS_W = 9;
    localparam int OUT_W  = 15;

    // Configuration register widths and indexes.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 10;
    localparam int RDZ_W      = 8;
    localparam int TDZ_W      = 8;
    localparam int AFS_W      = 9;
    localparam int OFS_W      = 10;

    localparam logic [CFG_ADDR_W-1:0] REG_RADIAL_DZ  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TWIST_DZ   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_AXIS_FS    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_OUTPUT_FS  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_INVERT_Y   = 3'd4;

    // Stream packing.
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 48;
    localparam int M_USER_W = 2;

    // Sum of squares and its square root (magnitude in Q.8).
    localparam int SUM_W    = 18;
    localparam int RAD_W    = 34;
    localparam int ROOT_W   = 17;
    localparam int SQ_REM_W = ROOT_W + 4;
    localparam int SQ_CNT_W = 5;

    // Quotient magnitude before the sign is applied.
    localparam int Q_W = 14;
    localparam logic [Q_W-1:0] OUT_MAX = 14'd16383;

endpackage

@@ src/rdss_isqrt.sv @@
// Bit-serial integer square root, one result bit per clock.
module rdss_isqrt (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [rdss_pkg::RAD_W-1:0]   radicand,
    output logic                         done,
    output logic [rdss_pkg::ROOT_W-1:0]  root
);

    logic                            busy_reg;
    logic                            done_reg;
    logic [rdss_pkg::SQ_CNT_W-1:0]   cnt_reg;
    logic [rdss_pkg::RAD_W-1:0]      vsh_reg;
    logic [rdss_pkg::SQ_REM_W-3:0]   rem_reg;
    logic [rdss_pkg::ROOT_W-1:0]     root_reg;

    logic [rdss_pkg::SQ_REM_W-1:0]   rem_sh;
    logic [rdss_pkg::SQ_REM_W-1:0]   trial;
    logic [rdss_pkg::SQ_REM_W-1:0]   rem_next;
    logic                            ge;

    // Bring down the next two radicand bits and try appending a one to the root.
    always_comb
    begin
        rem_sh   = {rem_reg, vsh_reg[rdss_pkg::RAD_W-1 -: 2]};
        trial    = {2'b00, root_reg, 2'b01};
        ge       = (rem_sh >= trial);
        rem_next = ge ? (rem_sh - trial) : rem_sh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= rdss_pkg::SQ_CNT_W'(rdss_pkg::ROOT_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            vsh_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            vsh_reg  <= {vsh_reg[rdss_pkg::RAD_W-3:0], 2'b00};
            rem_reg  <= rem_next[rdss_pkg::SQ_REM_W-3:0];
            root_reg <= {root_reg[rdss_pkg::ROOT_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

@@ src/radial_deadzone_stick_scaler.sv @@
// Top level of the radial deadzone scaler for a three-axis stick.
//
// Each input beat carries one stick sample (X, Y and twist) and produces exactly one output
// beat. The twist axis is zeroed when its magnitude is at or below the twist deadzone; the
// Euclidean magnitude of the three axes then decides whether the stick is active. An active
// sample is rescaled radially so that the deadzone maps to zero and the axis full scale maps to
// the output full scale, each axis keeping its direction unless Y is inverted; results are
// Q.FRAC_BITS, rounded to nearest and saturated to +-16383. A centered sample yields zeros;
// send_state flags every active sample and the first centered sample after activity. The
// block works on one sample at a time around a single shared multiplier. An active sample
// passes through five multiply steps for the squares and thresholds, one compare step, the
// 17-bit bit-serial square root, two multiply steps and one load step for the scale terms,
// then per axis one multiply and a 14-step restoring divider plus overhead, where an axis
// that saturates skips the divider steps; a centered sample goes from the compare step
// straight to the output. The result sits in an output register, so a new sample can be
// accepted while the previous result waits; the block stalls only when it finishes a result
// before the previous one has been taken. Configuration writes are meant to happen while no
// sample is in flight.
module radial_deadzone_stick_scaler #(
    parameter int FRAC_BITS = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    // Sample stream. tdata: axis_x [8:0], axis_y [17:9], axis_z [26:18], zero fill above.
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [rdss_pkg::S_DATA_W-1:0]        s_axis_tdata,

    // Result stream. tdata: out_x [14:0], out_y [29:15], out_z [44:30], zero fill above.
    // tuser: active [0], send_state [1].
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [rdss_pkg::M_DATA_W-1:0]        m_axis_tdata,
    output logic [rdss_pkg::M_USER_W-1:0]        m_axis_tuser,

    // Register write port.
    input  logic                                 cfg_we,
    input  logic [rdss_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [rdss_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    // Shared multiplier operand and product widths.
    localparam int MUL_A_W = rdss_pkg::ROOT_W;
    localparam int MUL_B_W = 27;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    // Divisor: the root, or the root times (axis full scale - deadzone).
    localparam int DEN_W   = rdss_pkg::ROOT_W + rdss_pkg::AFS_W;
    // Divider datapath: holds 2*numerator + divisor and the divisor shifted up by Q_W + 1.
    localparam int DIV_W   = PROD_W + FRAC_BITS + 5;
    localparam int CNT_W   = 4;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // Sequencer states.
    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_SQX   = 5'd1;
    localparam logic [4:0] ST_SQY   = 5'd2;
    localparam logic [4:0] ST_SQZ   = 5'd3;
    localparam logic [4:0] ST_DZ2   = 5'd4;
    localparam logic [4:0] ST_AF2   = 5'd5;
    localparam logic [4:0] ST_CHK   = 5'd6;
    localparam logic [4:0] ST_SQRT  = 5'd7;
    localparam logic [4:0] ST_DEN   = 5'd8;
    localparam logic [4:0] ST_NUMC  = 5'd9;
    localparam logic [4:0] ST_CMUL  = 5'd10;
    localparam logic [4:0] ST_AXM   = 5'd11;
    localparam logic [4:0] ST_LOAD  = 5'd12;
    localparam logic [4:0] ST_OVF   = 5'd13;
    localparam logic [4:0] ST_DIV   = 5'd14;
    localparam logic [4:0] ST_STORE = 5'd15;
    localparam logic [4:0] ST_OUT   = 5'd16;

    // Configuration registers.
    logic [rdss_pkg::RDZ_W-1:0]   rdz_reg;
    logic [rdss_pkg::TDZ_W-1:0]   tdz_reg;
    logic [rdss_pkg::AFS_W-1:0]   afs_reg;
    logic [rdss_pkg::OFS_W-1:0]   ofs_reg;
    logic                         inv_reg;

    logic [4:0]                   state_reg;
    logic [4:0]                   state_next;

    // Sample and working registers.
    logic signed [rdss_pkg::AXIS_W-1:0] x_reg;
    logic signed [rdss_pkg::AXIS_W-1:0] y_reg;
    logic signed [rdss_pkg::AXIS_W-1:0] z_reg;
    logic [rdss_pkg::SUM_W-1:0]   sum_reg;
    logic                         act_reg;
    logic                         sat_reg;
    logic                         was_reg;
    logic [PROD_W-1:0]            prod_reg;
    logic [DEN_W-1:0]             den_reg;
    logic [MUL_B_W-1:0]           c_reg;
    logic [1:0]                   axis_reg;
    logic [DIV_W-1:0]             rdiv_reg;
    logic [DIV_W-1:0]             dsh_reg;
    logic [rdss_pkg::Q_W-1:0]     q_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic [rdss_pkg::OUT_W-1:0]   ox_reg;
    logic [rdss_pkg::OUT_W-1:0]   oy_reg;
    logic [rdss_pkg::OUT_W-1:0]   oz_reg;

    // Output register.
    logic                         m_valid_reg;
    logic [rdss_pkg::M_DATA_W-1:0] m_data_reg;
    logic [rdss_pkg::M_USER_W-1:0] m_user_reg;

    logic                         s_accept;
    logic                         out_load;
    logic [rdss_pkg::AXIS_W-1:0]  in_zabs;
    logic [rdss_pkg::AXIS_W-1:0]  x_abs;
    logic [rdss_pkg::AXIS_W-1:0]  y_abs;
    logic [rdss_pkg::AXIS_W-1:0]  z_abs;
    logic [rdss_pkg::AXIS_W-1:0]  cur_abs;
    logic                         cur_neg;
    logic                         out_neg;
    logic [rdss_pkg::OUT_W-1:0]   q_signed;
    logic [MUL_A_W-1:0]           mul_a;
    logic [MUL_B_W-1:0]           mul_b;
    logic                         div_ge;
    logic                         sqrt_start;
    logic                         sqrt_done;
    logic [rdss_pkg::ROOT_W-1:0]  root;
    logic [rdss_pkg::AFS_W-1:0]   span;

    function automatic logic [rdss_pkg::AXIS_W-1:0] abs9(input logic [rdss_pkg::AXIS_W-1:0] v);
        abs9 = v[rdss_pkg::AXIS_W-1] ? (~v + 1'b1) : v;
    endfunction

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_load      = (state_reg == ST_OUT) && (!m_valid_reg || m_axis_tready);

    assign in_zabs = abs9(s_axis_tdata[3*rdss_pkg::AXIS_W-1:2*rdss_pkg::AXIS_W]);
    assign x_abs   = abs9(x_reg);
    assign y_abs   = abs9(y_reg);
    assign z_abs   = abs9(z_reg);
    assign span    = afs_reg - {1'b0, rdz_reg};
    assign div_ge  = (rdiv_reg >= dsh_reg);

    // Axis under work in the per-axis scaling loop.
    always_comb
    begin
        case (axis_reg)
            AXIS_X:
            begin
                cur_abs = x_abs;
                cur_neg = x_reg[rdss_pkg::AXIS_W-1];
            end
            AXIS_Y:
            begin
                cur_abs = y_abs;
                cur_neg = y_reg[rdss_pkg::AXIS_W-1];
            end
            default:
            begin
                cur_abs = z_abs;
                cur_neg = z_reg[rdss_pkg::AXIS_W-1];
            end
        endcase
        out_neg  = cur_neg ^ ((axis_reg == AXIS_Y) && inv_reg);
        q_signed = out_neg ? (~{1'b0, q_reg} + 1'b1) : {1'b0, q_reg};
    end

    // Operand selection for the one shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_SQX:
            begin
                mul_a = MUL_A_W'(x_abs);
                mul_b = MUL_B_W'(x_abs);
            end
            ST_SQY:
            begin
                mul_a = MUL_A_W'(y_abs);
                mul_b = MUL_B_W'(y_abs);
            end
            ST_SQZ:
            begin
                mul_a = MUL_A_W'(z_abs);
                mul_b = MUL_B_W'(z_abs);
            end
            ST_DZ2:
            begin
                mul_a = MUL_A_W'(rdz_reg);
                mul_b = MUL_B_W'(rdz_reg);
            end
            ST_AF2:
            begin
                mul_a = MUL_A_W'(afs_reg);
                mul_b = MUL_B_W'(afs_reg);
            end
            ST_DEN:
            begin
                mul_a = root;
                mul_b = MUL_B_W'(span);
            end
            ST_NUMC:
            begin
                // The root never falls below the deadzone in Q.8 once the sample is active.
                mul_a = root - {1'b0, rdz_reg, 8'h00};
                mul_b = MUL_B_W'(ofs_reg);
            end
            ST_AXM:
            begin
                mul_a = MUL_A_W'(cur_abs);
                mul_b = c_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign sqrt_start = (state_reg == ST_CHK) && act_reg;

    rdss_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand ({sum_reg, 16'h0000}),
        .done     (sqrt_done),
        .root     (root)
    );

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  state_next = s_accept ? ST_SQX : ST_IDLE;
            ST_SQX:   state_next = ST_SQY;
            ST_SQY:   state_next = ST_SQZ;
            ST_SQZ:   state_next = ST_DZ2;
            ST_DZ2:   state_next = ST_AF2;
            ST_AF2:   state_next = ST_CHK;
            ST_CHK:   state_next = act_reg ? ST_SQRT : ST_OUT;
            ST_SQRT:  state_next = sqrt_done ? ST_DEN : ST_SQRT;
            ST_DEN:   state_next = ST_NUMC;
            ST_NUMC:  state_next = ST_CMUL;
            ST_CMUL:  state_next = ST_AXM;
            ST_AXM:   state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_OVF;
            ST_OVF:   state_next = div_ge ? ST_STORE : ST_DIV;
            ST_DIV:   state_next = (cnt_reg == CNT_W'(1)) ? ST_STORE : ST_DIV;
            ST_STORE: state_next = (axis_reg == AXIS_Z) ? ST_OUT : ST_AXM;
            ST_OUT:   state_next = out_load ? ST_IDLE : ST_OUT;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Control state, configuration and the output handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            rdz_reg     <= 8'd20;
            tdz_reg     <= 8'd10;
            afs_reg     <= 9'd255;
            ofs_reg     <= 10'd750;
            inv_reg     <= 1'b0;
            was_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    rdss_pkg::REG_RADIAL_DZ: rdz_reg <= cfg_wdata[rdss_pkg::RDZ_W-1:0];
                    rdss_pkg::REG_TWIST_DZ:  tdz_reg <= cfg_wdata[rdss_pkg::TDZ_W-1:0];
                    rdss_pkg::REG_AXIS_FS:   afs_reg <= cfg_wdata[rdss_pkg::AFS_W-1:0];
                    rdss_pkg::REG_OUTPUT_FS: ofs_reg <= cfg_wdata[rdss_pkg::OFS_W-1:0];
                    rdss_pkg::REG_INVERT_Y:  inv_reg <= cfg_wdata[0];
                    default:                 ;
                endcase
            end
            if (m_valid_reg && m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
                was_reg     <= act_reg;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;

        if (s_accept)
        begin
            x_reg <= s_axis_tdata[rdss_pkg::AXIS_W-1:0];
            y_reg <= s_axis_tdata[2*rdss_pkg::AXIS_W-1:rdss_pkg::AXIS_W];
            // A twist inside its deadzone is dropped before the magnitude is formed.
            if (in_zabs <= {1'b0, tdz_reg})
            begin
                z_reg <= '0;
            end
            else
            begin
                z_reg <= s_axis_tdata[3*rdss_pkg::AXIS_W-1:2*rdss_pkg::AXIS_W];
            end
        end

        unique case (state_reg) inside
            ST_SQY:
            begin
                sum_reg <= prod_reg[rdss_pkg::SUM_W-1:0];
            end
            ST_SQZ, ST_DZ2:
            begin
                sum_reg <= sum_reg + prod_reg[rdss_pkg::SUM_W-1:0];
            end
            ST_AF2:
            begin
                act_reg <= (sum_reg != '0) && (sum_reg >= prod_reg[rdss_pkg::SUM_W-1:0]);
            end
            ST_CHK:
            begin
                // Unit gain when full scale is not past the deadzone or the stick is at or past it.
                sat_reg <= (afs_reg <= {1'b0, rdz_reg})
                           || (sum_reg >= prod_reg[rdss_pkg::SUM_W-1:0]);
                ox_reg  <= '0;
                oy_reg  <= '0;
                oz_reg  <= '0;
            end
            ST_NUMC:
            begin
                den_reg <= sat_reg ? DEN_W'(root) : prod_reg[DEN_W-1:0];
            end
            ST_CMUL:
            begin
                c_reg    <= sat_reg ? MUL_B_W'({ofs_reg, 8'h00}) : prod_reg[MUL_B_W-1:0];
                axis_reg <= AXIS_X;
            end
            ST_LOAD:
            begin
                // Twice the numerator plus the divisor gives round-half-up after flooring.
                rdiv_reg <= (DIV_W'(prod_reg) << (FRAC_BITS + 1)) + DIV_W'(den_reg);
                dsh_reg  <= DIV_W'(den_reg) << (rdss_pkg::Q_W + 1);
            end
            ST_OVF:
            begin
                q_reg   <= div_ge ? rdss_pkg::OUT_MAX : '0;
                dsh_reg <= dsh_reg >> 1;
                cnt_reg <= CNT_W'(rdss_pkg::Q_W);
            end
            ST_DIV:
            begin
                if (div_ge)
                begin
                    rdiv_reg <= rdiv_reg - dsh_reg;
                end
                q_reg   <= {q_reg[rdss_pkg::Q_W-2:0], div_ge};
                dsh_reg <= dsh_reg >> 1;
                cnt_reg <= cnt_reg - 1'b1;
            end
            ST_STORE:
            begin
                case (axis_reg)
                    AXIS_X:  ox_reg <= q_signed;
                    AXIS_Y:  oy_reg <= q_signed;
                    default: oz_reg <= q_signed;
                endcase
                axis_reg <= axis_reg + 1'b1;
            end
            default:
            begin
            end
        endcase

        if (out_load)
        begin
            m_data_reg <= {3'b000, oz_reg, oy_reg, ox_reg};
            m_user_reg <= {act_reg || was_reg, act_reg};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule

@@ src/rdss_checker.sv @@
// Port-level checker for the radial deadzone scaler and its bind to the top level.
module rdss_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [rdss_pkg::M_DATA_W-1:0]    m_axis_tdata,
    input  logic [rdss_pkg::M_USER_W-1:0]    m_axis_tuser
);

    // A centered result carries zero on all three axes.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[3*rdss_pkg::OUT_W-1:0] == '0)
        else $error("centered result with nonzero axis output");

    // Every active result is also a state to send.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[1])
        else $error("active result without send_state");

    // The block works on one sample at a time: it is busy right after taking one.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("sample accepted while another is in flight");

    // A stalled result beat holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

endmodule

bind radial_deadzone_stick_scaler rdss_checker u_rdss_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the radial deadzone stick scaler: directed and random samples.
module tb_top;

    // The fractional width of the outputs must match what the instance is built with.
    localparam int FRAC_BITS = 4;

    // The limit lies far above what the slowest sample takes, even when both sides
    // stall as long as they can. A stretch this long with no beat in either
    // direction can only mean the block has hung.
    localparam int HANG_LIMIT = 2000;

    // The drain at the end covers one full active sample and then some.
    localparam int DRAIN_CYCLES = 100;

    localparam logic signed [rdss_pkg::OUT_W-1:0] OUT_CLAMP = 15'sd16383;

    // One output beat, broken out into its fields.
    typedef struct packed {
        logic signed [rdss_pkg::OUT_W-1:0] out_x;
        logic signed [rdss_pkg::OUT_W-1:0] out_y;
        logic signed [rdss_pkg::OUT_W-1:0] out_z;
        logic                              active;
        logic                              send_state;
    } stick_out_t;

    // The scoreboard holds its own copy of the registers and of the activity
    // flag. It works out the result of every sample at the moment the sample is
    // accepted, and checks results in order as they leave the block.
    class stick_scoreboard;
        longint unsigned rdz = 20;
        longint unsigned tdz = 10;
        longint unsigned afs = 255;
        longint unsigned ofs = 750;
        bit              inv = 1'b0;
        bit              was_active = 1'b0;
        stick_out_t      awaited[$];
        int              errors = 0;

        // Mirror a register write. Bits above a register's width and indexes
        // past the last register are dropped, just as the block drops them.
        function void set_reg(logic [rdss_pkg::CFG_ADDR_W-1:0] addr,
                              logic [rdss_pkg::CFG_DATA_W-1:0] data);
            unique case (addr)
                rdss_pkg::REG_RADIAL_DZ: rdz = data[rdss_pkg::RDZ_W-1:0];
                rdss_pkg::REG_TWIST_DZ:  tdz = data[rdss_pkg::TDZ_W-1:0];
                rdss_pkg::REG_AXIS_FS:   afs = data[rdss_pkg::AFS_W-1:0];
                rdss_pkg::REG_OUTPUT_FS: ofs = data[rdss_pkg::OFS_W-1:0];
                rdss_pkg::REG_INVERT_Y:  inv = data[0];
                default: ;
            endcase
        endfunction

        // Integer square root, one result bit at a time from the top. The
        // magnitude in Q.8 never needs more than 18 bits.
        function longint unsigned magnitude_q8(longint unsigned v);
            longint unsigned root;
            longint unsigned trial;
            root = 0;
            for (int b = 17; b >= 0; b--)
            begin
                trial = root | (longint'(1) << b);
                if (trial * trial <= v)
                    root = trial;
            end
            return root;
        endfunction

        // One axis times the common scale, rounded to nearest with halves away
        // from zero, clamped to the output range, with the axis sign put back.
        function logic signed [rdss_pkg::OUT_W-1:0] scale_axis(int a, longint unsigned num,
                                                               longint unsigned den);
            longint unsigned mag;
            longint unsigned q;
            logic signed [rdss_pkg::OUT_W-1:0] v;
            mag = (a < 0) ? longint'(-a) : longint'(a);
            q = (2 * mag * num + den) / (2 * den);
            if (q > longint'(OUT_CLAMP))
                q = longint'(OUT_CLAMP);
            v = rdss_pkg::OUT_W'(q);
            return (a < 0) ? -v : v;
        endfunction

        function stick_out_t scale_sample(logic [rdss_pkg::AXIS_W-1:0] x_raw,
                                          logic [rdss_pkg::AXIS_W-1:0] y_raw,
                                          logic [rdss_pkg::AXIS_W-1:0] z_raw);
            int              xi;
            int              yi;
            int              zi;
            int              zmag;
            longint unsigned sumsq;
            longint unsigned mag;
            longint unsigned base;
            longint unsigned num;
            longint unsigned den;
            bit              act;
            stick_out_t      r;
            xi = int'($signed(x_raw));
            yi = int'($signed(y_raw));
            zi = int'($signed(z_raw));
            zmag = (zi < 0) ? -zi : zi;
            // Small twist is dropped before the magnitude is taken.
            if (longint'(zmag) <= tdz)
                zi = 0;
            sumsq = longint'(xi * xi + yi * yi + zi * zi);
            // A zero sample is never active, even with a zero deadzone.
            act = (sumsq != 0) && (sumsq >= rdz * rdz);
            r = '0;
            if (act)
            begin
                mag = magnitude_q8(sumsq << 16);
                base = ofs << (8 + FRAC_BITS);
                // The scale saturates to one at and past the full scale, and always when
                // the full scale does not lie above the deadzone.
                if (afs <= rdz || sumsq >= afs * afs)
                begin
                    num = base;
                    den = mag;
                end
                else
                begin
                    num = base * (mag - (rdz << 8));
                    den = mag * ((afs - rdz) << 8);
                end
                r.out_x = scale_axis(xi, num, den);
                r.out_y = scale_axis(yi, num, den);
                r.out_z = scale_axis(zi, num, den);
                if (inv)
                    r.out_y = -r.out_y;
            end
            r.active = act;
            r.send_state = act || was_active;
            was_active = act;
            return r;
        endfunction

        function void note_sample(logic [rdss_pkg::AXIS_W-1:0] x,
                                  logic [rdss_pkg::AXIS_W-1:0] y,
                                  logic [rdss_pkg::AXIS_W-1:0] z);
            awaited.push_back(scale_sample(x, y, z));
        endfunction

        function void check_result(logic [rdss_pkg::M_DATA_W-1:0] data,
                                   logic [rdss_pkg::M_USER_W-1:0] user);
            stick_out_t e;
            stick_out_t g;
            if (awaited.size() == 0)
            begin
                $error("result beat with no sample outstanding");
                errors++;
                return;
            end
            e = awaited.pop_front();
            g.out_x = data[rdss_pkg::OUT_W-1:0];
            g.out_y = data[2*rdss_pkg::OUT_W-1:rdss_pkg::OUT_W];
            g.out_z = data[3*rdss_pkg::OUT_W-1:2*rdss_pkg::OUT_W];
            g.active = user[0];
            g.send_state = user[1];
            if (g.out_x !== e.out_x)
            begin
                $error("out_x: expected %0d, got %0d", e.out_x, g.out_x);
                errors++;
            end
            if (g.out_y !== e.out_y)
            begin
                $error("out_y: expected %0d, got %0d", e.out_y, g.out_y);
                errors++;
            end
            if (g.out_z !== e.out_z)
            begin
                $error("out_z: expected %0d, got %0d", e.out_z, g.out_z);
                errors++;
            end
            if (g.active !== e.active)
            begin
                $error("active: expected %0d, got %0d", e.active, g.active);
                errors++;
            end
            if (g.send_state !== e.send_state)
            begin
                $error("send_state: expected %0d, got %0d", e.send_state, g.send_state);
                errors++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    // tdata: axis_x [8:0], axis_y [17:9], axis_z [26:18], zero fill above.
    logic [rdss_pkg::S_DATA_W-1:0]   s_axis_tdata = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    // tdata: out_x [14:0], out_y [29:15], out_z [44:30], zero fill above.
    logic [rdss_pkg::M_DATA_W-1:0]   m_axis_tdata;
    // tuser: active [0], send_state [1].
    logic [rdss_pkg::M_USER_W-1:0]   m_axis_tuser;
    logic                            cfg_we = 1'b0;
    logic [rdss_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [rdss_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    stick_scoreboard sb = new();

    // When set, neither side idles; the closing stretch of the run runs flat out.
    bit quiet = 1'b0;
    int stall_left = 0;
    int hang_cycles = 0;

    radial_deadzone_stick_scaler #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    always #5 clk = ~clk;

    // The result side now and then holds tready low for a random burst. The stall
    // count is kept in a plain variable so that tready sees one update per cycle.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 4) == 0)
        begin
            stall_left = $urandom_range(0, 18);
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // Every result beat is checked against the oldest outstanding sample.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    // Hang detection: any beat in either direction restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            hang_cycles <= 0;
        end
        else if (hang_cycles >= HANG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
        begin
            hang_cycles <= hang_cycles + 1;
        end
    end

    // Limit an axis value to what fits in the 9-bit two's complement field.
    function automatic logic [rdss_pkg::AXIS_W-1:0] to_axis(int v);
        if (v > 255)
            v = 255;
        if (v < -256)
            v = -256;
        return rdss_pkg::AXIS_W'(v);
    endfunction

    // Random samples are spread over the interesting regions: the whole field,
    // the ring around the radial deadzone, the centered stick (which produces
    // the single neutral beat after activity), the edge of the axis full scale,
    // and twist right at its deadzone.
    function automatic logic [3*rdss_pkg::AXIS_W-1:0] random_sample();
        int x;
        int y;
        int z;
        int r;
        int sgn;
        int pick;
        sgn = ($urandom_range(0, 1) == 1) ? 1 : -1;
        x = int'($signed(rdss_pkg::AXIS_W'($urandom)));
        y = int'($signed(rdss_pkg::AXIS_W'($urandom)));
        z = int'($signed(rdss_pkg::AXIS_W'($urandom)));
        pick = int'($urandom_range(0, 9));
        case (pick) inside
            5, 6:
            begin
                r = int'(sb.rdz);
                x = sgn * r + int'($urandom_range(0, 4)) - 2;
                y = int'($urandom_range(0, 6)) - 3;
                z = int'($urandom_range(0, 6)) - 3;
            end
            7:
            begin
                x = 0;
                y = 0;
                z = 0;
            end
            8:
            begin
                r = (sb.afs > 256) ? 256 : int'(sb.afs);
                x = int'($urandom_range(0, 4)) - 2;
                y = sgn * r + int'($urandom_range(0, 4)) - 2;
                z = int'($urandom_range(0, 6)) - 3;
            end
            9:
            begin
                x = int'($urandom_range(0, 127)) - 64;
                y = int'($urandom_range(0, 127)) - 64;
                z = sgn * (int'(sb.tdz) + int'($urandom_range(0, 1)));
            end
            default: ;
        endcase
        return {to_axis(z), to_axis(y), to_axis(x)};
    endfunction

    // Offer one sample and hold it until the block takes it. Now and then the
    // sender idles first for a random burst.
    task automatic send_sample(logic [rdss_pkg::AXIS_W-1:0] x, logic [rdss_pkg::AXIS_W-1:0] y,
                               logic [rdss_pkg::AXIS_W-1:0] z);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 19);
            repeat (gap)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
            end
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(rdss_pkg::S_DATA_W - 3*rdss_pkg::AXIS_W){1'b0}}, z, y, x};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_sample(x, y, z);
    endtask

    // Stop offering samples and wait until every outstanding result is out.
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [rdss_pkg::CFG_ADDR_W-1:0] addr,
                             logic [rdss_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= data;
        sb.set_reg(addr, data);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Load a full register set once the block is idle. Unused high bits carry
    // random junk, and a write to an index past the last register is mixed in;
    // both must be ignored.
    task automatic load_config(int rdz, int tdz, int afs, int ofs, int inv);
        drain();
        write_reg(rdss_pkg::REG_RADIAL_DZ, {2'($urandom), 8'(rdz)});
        write_reg(rdss_pkg::REG_TWIST_DZ, {2'($urandom), 8'(tdz)});
        write_reg(rdss_pkg::REG_AXIS_FS, {1'($urandom), 9'(afs)});
        write_reg(rdss_pkg::REG_OUTPUT_FS, 10'(ofs));
        write_reg(rdss_pkg::REG_INVERT_Y, {9'($urandom), 1'(inv)});
        write_reg(rdss_pkg::CFG_ADDR_W'(rdss_pkg::REG_INVERT_Y + $urandom_range(1, 3)),
                  rdss_pkg::CFG_DATA_W'($urandom));
    endtask

    // Random samples; idling stops for good once calm_from is reached.
    task automatic random_samples(int count, int calm_from);
        logic [3*rdss_pkg::AXIS_W-1:0] smp;
        for (int i = 0; i < count; i++)
        begin
            if (i == calm_from)
                quiet = 1'b1;
            smp = random_sample();
            send_sample(smp[rdss_pkg::AXIS_W-1:0],
                        smp[2*rdss_pkg::AXIS_W-1:rdss_pkg::AXIS_W],
                        smp[3*rdss_pkg::AXIS_W-1:2*rdss_pkg::AXIS_W]);
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: deadzone 20, twist deadzone 10, full scale 255, 750 out.
        send_sample(9'sd0, 9'sd0, 9'sd0);         // centered, nothing to send
        send_sample(9'sd255, 9'sd0, 9'sd0);       // full deflection on X
        send_sample(-9'sd256, -9'sd256, -9'sd256); // most negative on all axes
        send_sample(9'sd255, 9'sd255, 9'sd255);
        send_sample(9'sd0, 9'sd0, 9'sd0);         // first centered beat after activity
        send_sample(9'sd0, 9'sd0, 9'sd0);         // and the one after that stays quiet
        send_sample(9'sd19, 9'sd0, 9'sd0);        // just inside the deadzone
        send_sample(9'sd20, 9'sd0, 9'sd0);        // exactly on the deadzone edge
        send_sample(9'sd12, 9'sd16, 9'sd0);       // magnitude exactly 20 off-axis
        send_sample(9'sd0, 9'sd0, 9'sd10);        // twist at its deadzone is dropped
        send_sample(9'sd0, 9'sd0, -9'sd25);       // twist alone makes the stick active
        send_sample(9'sd0, 9'sd0, -9'sd256);      // twist of magnitude 256 is kept
        send_sample(9'sd180, 9'sd180, 9'sd0);     // just short of the full scale
        send_sample(9'sd181, 9'sd181, 9'sd0);     // just past it, scale saturates
        send_sample(9'sd100, -9'sd100, 9'sd11);
        send_sample(-9'sd1, 9'sd1, -9'sd1);

        // Inverted Y.
        load_config(20, 10, 255, 750, 1);
        send_sample(9'sd0, 9'sd255, 9'sd0);
        send_sample(9'sd30, -9'sd256, 9'sd0);

        // Full scale below the deadzone: any active sample gets the full scale.
        load_config(255, 0, 100, 1023, 0);
        send_sample(9'sd255, 9'sd0, 9'sd0);
        send_sample(-9'sd256, -9'sd256, 9'sd1);
        send_sample(9'sd200, 9'sd0, 9'sd0);

        // Zero deadzone: a zero sample is still centered.
        load_config(0, 255, 1, 1023, 1);
        send_sample(9'sd0, 9'sd0, 9'sd0);
        send_sample(9'sd1, 9'sd0, 9'sd0);
        send_sample(9'sd0, 9'sd0, 9'sd255);
        send_sample(9'sd0, 9'sd0, -9'sd256);

        // Random samples, first under the register extremes, then under random
        // settings. Every phase change waits for the block to drain completely.
        load_config(0, 0, 511, 1023, 1);
        random_samples(200, -1);
        load_config(255, 255, 1, 0, 0);
        random_samples(200, -1);
        load_config(255, 0, 511, 1023, 1);
        random_samples(200, -1);
        load_config(20, 10, 255, 750, 0);
        random_samples(200, -1);
        repeat (3)
        begin
            load_config($urandom_range(0, 255), $urandom_range(0, 40), $urandom_range(1, 511),
                        $urandom_range(0, 1023), $urandom_range(0, 1));
            random_samples(200, -1);
        end
        load_config($urandom_range(0, 60), $urandom_range(0, 40), $urandom_range(61, 511),
                    $urandom_range(0, 1023), $urandom_range(0, 1));
        random_samples(200, 60);

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
